/* src/dhcp_option_tlv_scanner_macros.svh */
//------------------------------------------------------------------------------
// DHCP option scanner assertion macros
// Shared concurrent assertion forms for the option scanner block.
//------------------------------------------------------------------------------
`ifndef DHCP_OPTION_TLV_SCANNER_MACROS_SVH
`define DHCP_OPTION_TLV_SCANNER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DOTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dots: same-cycle property violated");

// next-cycle implication, disabled while in reset
`define DOTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dots: next-cycle property violated");

`endif

/* src/dots_pkg.sv */
//------------------------------------------------------------------------------
// DHCP option scanner package
// Types, codes and constants shared by the option scanner modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package dots_pkg;

   localparam int unsigned MaxAreaBytes = 1024;
   localparam int unsigned OptW         = 8;
   localparam int unsigned LenW         = 10;
   localparam int unsigned StatusW      = 2;
   localparam int unsigned CookieLen    = 4;

   // position saturates at the smaller of the area limit and the counter range
   localparam int unsigned PosSatInt =
      (MaxAreaBytes - 1 < (1 << LenW) - 1) ? MaxAreaBytes - 1 : (1 << LenW) - 1;
   localparam logic [LenW-1:0] PosSat  = LenW'(PosSatInt);
   localparam bit              ClipLen = MaxAreaBytes < (1 << LenW);
   localparam logic [LenW-1:0] LenClip = LenW'(ClipLen ? MaxAreaBytes : 0);

   localparam logic [OptW-1:0] CodePad     = 8'd0;
   localparam logic [OptW-1:0] CodeEnd     = 8'd255;
   localparam logic [OptW-1:0] SearchReset = 8'd53;

   typedef enum logic [2:0] {
      PH_COOKIE,
      PH_CODE,
      PH_LEN,
      PH_SKIP,
      PH_DONE
   } phase_type;

   typedef enum logic [StatusW-1:0] {
      ST_FOUND,
      ST_NONE,
      ST_COOKIE,
      ST_BOUNDS
   } status_type;

   typedef struct packed {
      logic [OptW-1:0] opt_byte;
      logic [LenW-1:0] area_length;
      logic            last_byte;
   } req_type;

   typedef struct packed {
      logic            found;
      status_type      status;
      logic [LenW-1:0] value_offset;
      logic [OptW-1:0] value_length;
   } rsp_type;

   typedef struct packed {
      logic [LenW-1:0] pos;
      phase_type       phase;
      logic [OptW-1:0] skip;
      logic            matched;
      logic            verdict;
   } scan_type;

   localparam scan_type ScanRestart = '{
      pos:     '0,
      phase:   PH_COOKIE,
      skip:    '0,
      matched: 1'b0,
      verdict: 1'b0
   };

   function automatic logic [OptW-1:0] cookie_byte(input logic [1:0] idx);
      logic [OptW-1:0] b;
      case (idx)
         2'd0:    b = 8'd99;
         2'd1:    b = 8'd130;
         2'd2:    b = 8'd83;
         default: b = 8'd99;
      endcase
      return b;
   endfunction

endpackage

/* src/dots_req_if.sv */
//------------------------------------------------------------------------------
// DHCP option scanner request channel
// Valid/ready channel carrying one options-area byte with its framing.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dots_req_if import dots_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [OptW-1:0] opt_byte;
   logic [LenW-1:0] area_length;
   logic            last_byte;

   modport source (output valid, output opt_byte, output area_length, output last_byte,
                   input ready);
   modport sink   (input valid, input opt_byte, input area_length, input last_byte,
                   output ready);
endinterface

/* src/dots_rsp_if.sv */
//------------------------------------------------------------------------------
// DHCP option scanner response channel
// Valid/ready channel carrying one scan verdict.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dots_rsp_if import dots_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               found;
   logic [StatusW-1:0] status;
   logic [LenW-1:0]    value_offset;
   logic [OptW-1:0]    value_length;

   modport source (output valid, output found, output status, output value_offset,
                   output value_length, input ready);
   modport sink   (input valid, input found, input status, input value_offset,
                   input value_length, output ready);
endinterface

/* src/dots_csr_if.sv */
//------------------------------------------------------------------------------
// DHCP option scanner configuration channel
// Valid/ready write channel for the search code register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dots_csr_if import dots_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [OptW-1:0] search_code;

   modport source (output valid, output search_code, input ready);
   modport sink   (input valid, input search_code, output ready);
endinterface

/* src/dots_step.sv */
//------------------------------------------------------------------------------
// DHCP option scanner step logic
// Next scan state and verdict for one options byte, purely combinational.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module dots_step import dots_pkg::*; (
   input  scan_type        scan,
   input  req_type         item,
   input  logic [OptW-1:0] search_code,
   output scan_type        scan_next,
   output logic            emit,
   output rsp_type         rsp
);

   logic [LenW:0]      len_eff;
   logic [LenW:0]      pos_x;
   logic [LenW:0]      pos1;
   logic [LenW:0]      lim;
   logic [OptW-1:0]    skip_dec;
   logic               active;
   status_type         st;
   logic [LenW-1:0]    off;
   logic [OptW-1:0]    vlen;

   assign len_eff  = (ClipLen && item.area_length > LenClip) ? {1'b0, LenClip}
                                                             : {1'b0, item.area_length};
   assign pos_x    = {1'b0, scan.pos};
   assign pos1     = pos_x + (LenW+1)'(1);
   // value ends at length byte + 1 + value length
   assign lim      = pos1 + (LenW+1)'(item.opt_byte);
   assign skip_dec = (scan.skip != '0) ? scan.skip - OptW'(1) : scan.skip;
   assign active   = !scan.verdict && (scan.phase != PH_DONE);

   always_comb begin
      scan_next = scan;
      emit      = 1'b0;
      st        = ST_NONE;
      off       = '0;
      vlen      = '0;

      if (active) begin
         if (scan.phase == PH_COOKIE && len_eff < (LenW+1)'(CookieLen)) begin
            emit = 1'b1;
            st   = ST_COOKIE;
         end else if (pos_x >= len_eff) begin
            emit = 1'b1;
            st   = ST_NONE;
         end else begin
            case (scan.phase)
               PH_COOKIE: begin
                  if (item.opt_byte != cookie_byte(scan.pos[1:0])) begin
                     emit = 1'b1;
                     st   = ST_COOKIE;
                  end else if (scan.pos == LenW'(CookieLen - 1)) begin
                     scan_next.phase = PH_CODE;
                  end
               end
               PH_CODE: begin
                  if (item.opt_byte == CodeEnd) begin
                     emit = 1'b1;
                     st   = ST_NONE;
                  end else if (item.opt_byte != CodePad) begin
                     // no room left for the length byte
                     if (pos1 >= len_eff) begin
                        emit = 1'b1;
                        st   = ST_BOUNDS;
                     end else begin
                        scan_next.matched = (item.opt_byte == search_code);
                        scan_next.phase   = PH_LEN;
                     end
                  end
               end
               PH_LEN: begin
                  if (scan.matched) begin
                     emit = 1'b1;
                     if (item.opt_byte == '0 || lim >= len_eff) begin
                        st = ST_BOUNDS;
                     end else begin
                        st   = ST_FOUND;
                        off  = pos1[LenW-1:0];
                        vlen = item.opt_byte;
                     end
                  end else if (lim >= len_eff) begin
                     emit = 1'b1;
                     st   = ST_BOUNDS;
                  end else if (item.opt_byte == '0) begin
                     scan_next.phase = PH_CODE;
                  end else begin
                     scan_next.skip  = item.opt_byte;
                     scan_next.phase = PH_SKIP;
                  end
                  scan_next.matched = 1'b0;
               end
               PH_SKIP: begin
                  scan_next.skip = skip_dec;
                  if (skip_dec == '0) begin
                     scan_next.phase = PH_CODE;
                  end
               end
               default: begin
                  emit = 1'b1;
                  st   = ST_NONE;
               end
            endcase
         end
      end

      // area ended before any verdict
      if (!emit && !scan.verdict && item.last_byte) begin
         emit = 1'b1;
         st   = ST_NONE;
      end

      if (emit) begin
         scan_next.verdict = 1'b1;
         scan_next.phase   = PH_DONE;
      end

      if (scan.pos < PosSat) begin
         scan_next.pos = scan.pos + LenW'(1);
      end

      if (item.last_byte) begin
         scan_next = ScanRestart;
      end

      rsp.found        = (st == ST_FOUND);
      rsp.status       = st;
      rsp.value_offset = off;
      rsp.value_length = vlen;
   end

endmodule

/* src/dots_rsp_stage.sv */
//------------------------------------------------------------------------------
// DHCP option scanner result register
// Holds one verdict until the response channel takes it.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module dots_rsp_stage import dots_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  rsp_type   load_data,
   output logic      free,
   dots_rsp_if.source rsp_out
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free = !valid_ff || rsp_out.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_out.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_out.valid        = valid_ff;
   assign rsp_out.found        = data_ff.found;
   assign rsp_out.status       = data_ff.status;
   assign rsp_out.value_offset = data_ff.value_offset;
   assign rsp_out.value_length = data_ff.value_length;

endmodule

/* src/dhcp_option_tlv_scanner.sv */
//------------------------------------------------------------------------------
// DHCP option scanner top level
// Each byte is captured in the input register; its verdict goes to the result register on rsp.
// Throughput: one byte per cycle unless stalled; the combinational scan step bounds the rate.
// The input register stalls only while a verdict waits on a full result register.
// Reset (synchronous, active high) clears the scan state and both registers
// and sets the search code to 53.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dhcp_option_tlv_scanner_macros.svh"

module dhcp_option_tlv_scanner import dots_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dots_req_if.sink   req_in,
   dots_rsp_if.source rsp_out,
   dots_csr_if.sink   csr_wr
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_type         in_item_ff;
   scan_type        scan_ff;
   scan_type        scan_in;
   logic [OptW-1:0] search_code_ff;
   logic [OptW-1:0] search_code_in;

   scan_type        scan_next;
   logic            emit;
   rsp_type         step_rsp;
   logic            rsp_free;
   logic            advance;
   logic            req_take;

   logic            in_stalled;
   logic            area_end;
   logic            rsp_miss;
   logic            rsp_blank;

   // configuration writes are always taken
   assign csr_wr.ready   = 1'b1;
   assign search_code_in = (csr_wr.valid) ? csr_wr.search_code : search_code_ff;

   assign advance      = in_valid_ff && (!emit || rsp_free);
   assign req_in.ready = !in_valid_ff || advance;
   assign req_take     = req_in.valid && req_in.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign scan_in = advance ? scan_next : scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         scan_ff        <= ScanRestart;
         search_code_ff <= SearchReset;
      end else begin
         in_valid_ff    <= in_valid_in;
         scan_ff        <= scan_in;
         search_code_ff <= search_code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.opt_byte    <= req_in.opt_byte;
         in_item_ff.area_length <= req_in.area_length;
         in_item_ff.last_byte   <= req_in.last_byte;
      end
   end

   dots_step u_step (
      .scan        (scan_ff),
      .item        (in_item_ff),
      .search_code (search_code_ff),
      .scan_next   (scan_next),
      .emit        (emit),
      .rsp         (step_rsp)
   );

   dots_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .load_data (step_rsp),
      .free      (rsp_free),
      .rsp_out   (rsp_out)
   );

   assign in_stalled = in_valid_ff && !advance;
   assign area_end   = advance && in_item_ff.last_byte;
   assign rsp_miss   = rsp_out.valid && rsp_out.status != ST_FOUND;
   assign rsp_blank  = !rsp_out.found && rsp_out.value_offset == '0 &&
                       rsp_out.value_length == '0;

   `DOTS_ASSERT_NEXT(a_in_hold, clock, reset, in_stalled, in_valid_ff && $stable(in_item_ff))
   `DOTS_ASSERT_NEXT(a_area_restart, clock, reset, area_end, scan_ff == ScanRestart)
   `DOTS_ASSERT_SAME(a_done_verdict, clock, reset, scan_ff.verdict, scan_ff.phase == PH_DONE)
   `DOTS_ASSERT_SAME(a_miss_zero, clock, reset, rsp_miss, rsp_blank)

endmodule

/* sim/tb.sv */
//------------------------------------------------------------------------------
// DHCP option scanner testbench
// Feeds options areas byte by byte through the request channel, predicts the
// one verdict per area from a local scan model and checks every response in
// order. A directed table runs first, then random areas under several search
// codes, with bursty input and a stalling response side.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import dots_pkg::*; ();

   localparam int unsigned IdleLimit    = 2000;
   localparam int unsigned HoldCycles   = 300;
   localparam int unsigned SettleCycles = 4;
   localparam int unsigned PhaseBytes   = 80;
   localparam int unsigned PosTop       = (MaxAreaBytes - 1 < 1023) ? MaxAreaBytes - 1 : 1023;
   localparam logic [OptW-1:0] CookieSeq [4] = '{8'd99, 8'd130, 8'd83, 8'd99};

   typedef struct packed {
      req_type req;
      bit      typed;
      bit      has;
      rsp_type rsp;
   } dir_row_type;

   localparam rsp_type NoRsp = '{1'b0, ST_NONE, 10'd0, 8'd0};

   // typed rows carry their verdict; the rest go through the scan model
   localparam dir_row_type DirTable [31] = '{
      // well-formed area: pad, skipped entry, then the searched option
      '{'{8'd99,  10'd16, 1'b0}, 1'b1, 1'b0, NoRsp},
      '{'{8'd130, 10'd16, 1'b0}, 1'b1, 1'b0, NoRsp},
      '{'{8'd83,  10'd16, 1'b0}, 1'b1, 1'b0, NoRsp},
      '{'{8'd99,  10'd16, 1'b0}, 1'b1, 1'b0, NoRsp},
      '{'{8'd0,   10'd16, 1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd7,   10'd16, 1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd1,   10'd16, 1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd200, 10'd16, 1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd53,  10'd16, 1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd3,   10'd16, 1'b0}, 1'b1, 1'b1, '{1'b1, ST_FOUND, 10'd10, 8'd3}},
      '{'{8'd0,   10'd16, 1'b1}, 1'b1, 1'b0, NoRsp},
      // area too short for the cookie
      '{'{8'd99,  10'd0,  1'b1}, 1'b1, 1'b1, '{1'b0, ST_COOKIE, 10'd0, 8'd0}},
      // cookie mismatch on the second byte
      '{'{8'd99,  10'd20, 1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd131, 10'd20, 1'b1}, 1'b1, 1'b1, '{1'b0, ST_COOKIE, 10'd0, 8'd0}},
      // code on the final area byte
      '{'{8'd99,  10'd5,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd130, 10'd5,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd83,  10'd5,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd99,  10'd5,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd12,  10'd5,  1'b1}, 1'b1, 1'b1, '{1'b0, ST_BOUNDS, 10'd0, 8'd0}},
      // end code
      '{'{8'd99,  10'd8,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd130, 10'd8,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd83,  10'd8,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd99,  10'd8,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd255, 10'd8,  1'b1}, 1'b1, 1'b1, '{1'b0, ST_NONE, 10'd0, 8'd0}},
      // byte beyond the area
      '{'{8'd99,  10'd4,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd130, 10'd4,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd83,  10'd4,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd99,  10'd4,  1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd5,   10'd4,  1'b1}, 1'b1, 1'b1, '{1'b0, ST_NONE, 10'd0, 8'd0}},
      // stream ends before any verdict, largest area length
      '{'{8'd99,  10'd1023, 1'b0}, 1'b0, 1'b0, NoRsp},
      '{'{8'd130, 10'd1023, 1'b1}, 1'b1, 1'b1, '{1'b0, ST_NONE, 10'd0, 8'd0}}
   };

   logic clock;
   logic reset;

   dots_req_if req_if ();
   dots_rsp_if rsp_if ();
   dots_csr_if csr_if ();

   dhcp_option_tlv_scanner dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_if),
      .rsp_out (rsp_if),
      .csr_wr  (csr_if)
   );

   // scan model state
   logic [OptW-1:0] search_cfg;
   logic [LenW-1:0] sc_pos;
   phase_type       sc_phase;
   logic [OptW-1:0] sc_skip;
   logic            sc_matched;
   logic            sc_verdict;

   rsp_type     verdict_q [$];
   req_type     area_q [$];
   rsp_type     want;
   int unsigned failures      = 0;
   int unsigned live_bytes    = 0;
   int unsigned burst_left    = 0;
   int unsigned stall_cycles  = 0;
   bit          hold_off_pending = 1'b0;

   initial clock = 1'b0;
   always #5ns clock = ~clock;

   task automatic restart_scan();
      sc_pos     = '0;
      sc_phase   = PH_COOKIE;
      sc_skip    = '0;
      sc_matched = 1'b0;
      sc_verdict = 1'b0;
   endtask

   task automatic predict_verdict(input req_type r, output bit has, output rsp_type res);
      int unsigned alen;
      int unsigned p;
      int unsigned lim;
      bit          emit;
      status_type  st;
      logic [LenW-1:0] off;
      logic [OptW-1:0] vl;
      alen = r.area_length;
      if (alen > MaxAreaBytes) alen = MaxAreaBytes;
      p    = sc_pos;
      emit = 1'b0;
      st   = ST_NONE;
      off  = '0;
      vl   = '0;
      if (sc_verdict || sc_phase == PH_DONE) begin
         // swallow until the end of the area
      end else if (sc_phase == PH_COOKIE && alen < CookieLen) begin
         emit = 1'b1; st = ST_COOKIE;
      end else if (p >= alen) begin
         emit = 1'b1; st = ST_NONE;
      end else begin
         case (sc_phase)
            PH_COOKIE: begin
               if (r.opt_byte != CookieSeq[p % 4]) begin
                  emit = 1'b1; st = ST_COOKIE;
               end else if (p == CookieLen - 1) begin
                  sc_phase = PH_CODE;
               end
            end
            PH_CODE: begin
               if (r.opt_byte == CodeEnd) begin
                  emit = 1'b1; st = ST_NONE;
               end else if (r.opt_byte != CodePad) begin
                  // no room left for the length byte
                  if (p + 1 >= alen) begin
                     emit = 1'b1; st = ST_BOUNDS;
                  end else begin
                     sc_matched = (r.opt_byte == search_cfg);
                     sc_phase   = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               lim = p + 1 + r.opt_byte;
               if (sc_matched) begin
                  if (r.opt_byte == 0 || lim >= alen) begin
                     emit = 1'b1; st = ST_BOUNDS;
                  end else begin
                     emit = 1'b1; st = ST_FOUND;
                     off  = LenW'(p + 1);
                     vl   = r.opt_byte;
                  end
               end else if (lim >= alen) begin
                  emit = 1'b1; st = ST_BOUNDS;
               end else if (r.opt_byte == 0) begin
                  sc_phase = PH_CODE;
               end else begin
                  sc_skip  = r.opt_byte;
                  sc_phase = PH_SKIP;
               end
               sc_matched = 1'b0;
            end
            PH_SKIP: begin
               if (sc_skip != 0) sc_skip = sc_skip - 1'b1;
               if (sc_skip == 0) sc_phase = PH_CODE;
            end
            default: begin
               emit = 1'b1; st = ST_NONE;
            end
         endcase
      end
      // last byte without a verdict yet closes the area as not found
      if (!emit && !sc_verdict && r.last_byte) begin
         emit = 1'b1; st = ST_NONE;
      end
      has = emit;
      res = '{found: (st == ST_FOUND), status: st, value_offset: off, value_length: vl};
      if (emit) begin
         sc_verdict = 1'b1;
         sc_phase   = PH_DONE;
      end
      if (sc_pos < PosTop) sc_pos = sc_pos + 1'b1;
      if (r.last_byte) restart_scan();
   endtask

   // offer one byte, hold it until transfer, then maybe open a gap
   task automatic send_byte(input req_type r, input bit typed, input bit t_has,
                            input rsp_type t_rsp);
      bit      has;
      rsp_type res;
      req_if.valid       <= 1'b1;
      req_if.opt_byte    <= r.opt_byte;
      req_if.area_length <= r.area_length;
      req_if.last_byte   <= r.last_byte;
      do @(posedge clock); while (!req_if.ready);
      live_bytes++;
      predict_verdict(r, has, res);
      if (typed) begin
         has = t_has;
         res = t_rsp;
      end
      if (has) verdict_q.push_back(res);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_search(input logic [OptW-1:0] code);
      csr_if.valid       <= 1'b1;
      csr_if.search_code <= code;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      search_cfg = code;
   endtask

   // mostly well-formed areas with random content, the rest noise
   task automatic build_area();
      logic [OptW-1:0] body [$];
      logic [LenW-1:0] alen;
      int n;
      int r;
      int vlen;
      int alen_i;
      body.delete();
      area_q.delete();
      if ($urandom_range(0, 99) < 80) begin
         foreach (CookieSeq[i]) body.push_back(CookieSeq[i]);
         if ($urandom_range(0, 9) == 0) body[$urandom_range(0, 3)] = OptW'($urandom);
         n = $urandom_range(1, 5);
         repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               body.push_back(CodePad);
            end else if (r < 16) begin
               body.push_back(CodeEnd);
            end else begin
               body.push_back(r < 50 ? search_cfg : OptW'($urandom_range(1, 254)));
               vlen = (r % 8 == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
               body.push_back(OptW'(vlen));
               repeat (vlen < 10 ? vlen : 10) body.push_back(OptW'($urandom));
            end
         end
         r = $urandom_range(0, 99);
         if (r < 70)      alen_i = body.size() + $urandom_range(1, 4);
         else if (r < 85) alen_i = body.size() - $urandom_range(0, 3);
         else if (r < 93) alen_i = $urandom_range(64, 1023);
         else             alen_i = $urandom_range(0, 7);
         alen = LenW'(alen_i);
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) body.push_back(OptW'($urandom));
         if ($urandom_range(0, 9) == 0) begin
            n    = $urandom_range(1, body.size());
            body = body[0:n-1];
         end
         foreach (body[i])
            area_q.push_back('{body[i], alen, (i == body.size() - 1)});
      end else begin
         n    = $urandom_range(1, 12);
         alen = LenW'($urandom_range(0, 1023));
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) alen = LenW'($urandom_range(0, 1023));
            area_q.push_back('{OptW'($urandom), alen, (i == n - 1)});
         end
      end
   endtask

   // response side: changing stall patterns plus one long hold-off
   initial begin
      int mode;
      int mode_left;
      mode      = 0;
      mode_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 60);
         end
         mode_left--;
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= $urandom_range(0, 1);
               2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= (mode_left % 2 == 0);
            endcase
         end
      end
   end

   // response check against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (verdict_q.size() == 0) begin
            $error("unexpected verdict: status %0d offset %0d length %0d",
                   rsp_if.status, rsp_if.value_offset, rsp_if.value_length);
            failures++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_if.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_if.found);
               failures++;
            end
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
               failures++;
            end
            if (rsp_if.value_offset !== want.value_offset) begin
               $error("value_offset: expected %0d, actual %0d",
                      want.value_offset, rsp_if.value_offset);
               failures++;
            end
            if (rsp_if.value_length !== want.value_length) begin
               $error("value_length: expected %0d, actual %0d",
                      want.value_length, rsp_if.value_length);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= IdleLimit) begin
         $error("no transfer for %0d cycles, %0d verdicts outstanding",
                stall_cycles, verdict_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int unsigned quota;
      logic [OptW-1:0] code;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.opt_byte    <= '0;
      req_if.area_length <= '0;
      req_if.last_byte   <= 1'b0;
      csr_if.valid       <= 1'b0;
      csr_if.search_code <= '0;
      search_cfg = SearchReset;
      restart_scan();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DirTable[i])
         send_byte(DirTable[i].req, DirTable[i].typed, DirTable[i].has, DirTable[i].rsp);

      for (int phase = 1; phase <= 5; phase++) begin
         drain();
         case (phase)
            2:       code = '0;
            3:       code = '1;
            5:       code = SearchReset;
            default: code = OptW'($urandom);
         endcase
         write_search(code);
         // fill the block while the response side holds off
         if (phase == 2) hold_off_pending = 1'b1;
         quota = live_bytes + PhaseBytes;
         while (live_bytes < quota) begin
            build_area();
            foreach (area_q[j]) send_byte(area_q[j], 1'b0, 1'b0, NoRsp);
         end
      end

      drain();
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
